// ===== rtl/ctf_pkg.sv =====
// ----------------------------------------------------------------------------
// ctf_pkg
// Shared types and constants of the clock text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

   // Depth of the queue between the front and back parts
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // Configuration register indexes
   localparam logic [1:0] CSR_SHOW_SECONDS = 2'd0;
   localparam logic [1:0] CSR_USE_24H      = 2'd1;
   localparam logic [1:0] CSR_SHOW_WEEKDAY = 2'd2;

   // One request: a calendar time
   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } ctf_req_type;

   // One result: a character of the clock text
   typedef struct packed {
      logic [6:0] text_char;
      logic       is_last;
   } ctf_rsp_type;

   // Format options
   typedef struct packed {
      logic show_seconds;
      logic use_24h;
      logic show_weekday;
   } ctf_flags_type;

   // Classified request handed from front to back
   typedef struct packed {
      logic [2:0]    weekday;
      logic [3:0]    hour_tens;
      logic [3:0]    hour_units;
      logic [3:0]    min_tens;
      logic [3:0]    min_units;
      logic [3:0]    sec_tens;
      logic [3:0]    sec_units;
      logic          pm;
      ctf_flags_type flags;
   } ctf_entry_type;

endpackage

`default_nettype wire

// ===== rtl/ctf_front.sv =====
// ----------------------------------------------------------------------------
// ctf_front
// Accepts a request, splits the time fields into digits and finds the weekday
// by Zeller's congruence over a four-stage pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_front
   import ctf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  ctf_req_type        req_data,
   input  ctf_flags_type      flags,
   output logic               push,
   output ctf_entry_type      push_entry
);

   // year / 400 by reciprocal, exact for 14-bit years
   localparam logic [12:0] YR_RECIP   = 13'd5243;
   localparam int          YR_SHIFT   = 21;
   // s / 7 by reciprocal, exact for 8-bit sums
   localparam logic [8:0]  MOD7_RECIP = 9'd293;
   localparam int          MOD7_SHIFT = 11;
   // (13 * (m + 1)) / 5 for m = 0 .. 15
   localparam logic [5:0] MONTH_TERM [16] = '{
      6'd2,  6'd5,  6'd7,  6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
      6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
   };

   // Split a value below 64 into tens and units digits
   function automatic logic [7:0] split_digits(input logic [5:0] v);
      logic [13:0] prod;
      logic [2:0]  tens;
      logic [5:0]  units;
      prod  = 14'(v) * 14'd205;
      tens  = prod[13:11];
      units = v - (6'(tens) * 6'd10);
      return {1'b0, tens, units[3:0]};
   endfunction

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [13:0]   year_s1_ff;
   logic [5:0]    q_s1_ff;
   logic          below3_s1_ff;
   logic [5:0]    mterm_s1_ff, mterm_s2_ff, mterm_s3_ff;
   logic [4:0]    day_s1_ff, day_s2_ff, day_s3_ff;
   ctf_entry_type entry_s1_ff, entry_s2_ff, entry_s3_ff, entry_s4_ff;
   logic [9:0]    y_s2_ff;
   logic [2:0]    c_s3_ff;
   logic [6:0]    k_s3_ff;
   logic [7:0]    s_s4_ff;

   logic [26:0]   q_prod;
   logic          below3;
   logic [3:0]    m_adj;
   logic [4:0]    hour_shown;
   logic [7:0]    hour_dig, min_dig, sec_dig;
   ctf_entry_type entry_s1_in;
   logic [13:0]   r_full;
   logic [9:0]    y_s2_in;
   logic [2:0]    c_s3_in;
   logic [9:0]    k_full;
   logic [7:0]    s_s4_in;
   logic [16:0]   t_prod;
   logic [7:0]    h_full;
   logic [2:0]    h;

   // Stage 1: digits, shown hour, month shift and year quotient
   always_comb begin
      q_prod = 27'(req_data.year) * 27'(YR_RECIP);
      below3 = req_data.month < 4'd3;
      m_adj  = below3 ? req_data.month + 4'd12 : req_data.month;
      if (flags.use_24h) begin
         hour_shown = req_data.hour;
      end else if (req_data.hour >= 5'd24) begin
         hour_shown = req_data.hour - 5'd24;
      end else if (req_data.hour >= 5'd12) begin
         hour_shown = req_data.hour - 5'd12;
      end else begin
         hour_shown = req_data.hour;
      end
      if (!flags.use_24h && hour_shown == 5'd0) begin
         hour_shown = 5'd12;
      end
      hour_dig = split_digits(6'(hour_shown));
      min_dig  = split_digits(req_data.minute);
      sec_dig  = split_digits(req_data.second);
      entry_s1_in.weekday    = 3'd0;
      entry_s1_in.hour_tens  = hour_dig[7:4];
      entry_s1_in.hour_units = hour_dig[3:0];
      entry_s1_in.min_tens   = min_dig[7:4];
      entry_s1_in.min_units  = min_dig[3:0];
      entry_s1_in.sec_tens   = sec_dig[7:4];
      entry_s1_in.sec_units  = sec_dig[3:0];
      entry_s1_in.pm         = req_data.hour >= 5'd12;
      entry_s1_in.flags      = flags;
   end

   // Stage 2: shifted year in 399 .. 799
   always_comb begin
      r_full  = year_s1_ff - (14'(q_s1_ff) * 14'd400);
      y_s2_in = 10'(r_full[8:0]) + 10'd400 - 10'(below3_s1_ff);
   end

   // Stage 3: century and year of century
   always_comb begin
      if (y_s2_ff >= 10'd700) begin
         c_s3_in = 3'd7;
      end else if (y_s2_ff >= 10'd600) begin
         c_s3_in = 3'd6;
      end else if (y_s2_ff >= 10'd500) begin
         c_s3_in = 3'd5;
      end else if (y_s2_ff >= 10'd400) begin
         c_s3_in = 3'd4;
      end else begin
         c_s3_in = 3'd3;
      end
      k_full = y_s2_ff - (10'(c_s3_in) * 10'd100);
   end

   // Stage 4: congruence sum
   always_comb begin
      s_s4_in = 8'(day_s3_ff) + 8'(mterm_s3_ff) + 8'(k_s3_ff) + 8'(k_s3_ff >> 2)
              + 8'(c_s3_ff >> 2) + (8'(c_s3_ff) * 8'd5);
   end

   // Reduce mod 7 and rotate so Sunday is zero
   always_comb begin
      t_prod = 17'(s_s4_ff) * 17'(MOD7_RECIP);
      h_full = s_s4_ff - (8'(t_prod[16:MOD7_SHIFT]) * 8'd7);
      h      = h_full[2:0];
      push_entry         = entry_s4_ff;
      push_entry.weekday = (h == 3'd0) ? 3'd6 : h - 3'd1;
      push               = s4_valid_ff;
   end

   // Advance the pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance the pipeline payload
   always_ff @(posedge clock) begin
      year_s1_ff   <= req_data.year;
      q_s1_ff      <= q_prod[YR_SHIFT +: 6];
      below3_s1_ff <= below3;
      mterm_s1_ff  <= MONTH_TERM[m_adj];
      day_s1_ff    <= req_data.day;
      entry_s1_ff  <= entry_s1_in;

      y_s2_ff      <= y_s2_in;
      mterm_s2_ff  <= mterm_s1_ff;
      day_s2_ff    <= day_s1_ff;
      entry_s2_ff  <= entry_s1_ff;

      c_s3_ff      <= c_s3_in;
      k_s3_ff      <= k_full[6:0];
      mterm_s3_ff  <= mterm_s2_ff;
      day_s3_ff    <= day_s2_ff;
      entry_s3_ff  <= entry_s2_ff;

      s_s4_ff      <= s_s4_in;
      entry_s4_ff  <= entry_s3_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/ctf_queue.sv =====
// ----------------------------------------------------------------------------
// ctf_queue
// Small queue of classified requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_queue
   import ctf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  ctf_entry_type      push_entry,
   input  wire logic          pop,
   output ctf_entry_type      head_entry,
   output logic               empty,
   output logic               full
);

   ctf_entry_type        entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff;
   logic                 do_pop;

   // Show the head and the fill state
   always_comb begin
      head_entry = entries_ff[rd_ptr_ff];
      empty      = count_ff == Q_CNT_W'(0);
      full       = count_ff == Q_CNT_W'(Q_DEPTH);
      do_pop     = pop && !empty;
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
   end

   // Store the pushed request
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ctf_back.sv =====
// ----------------------------------------------------------------------------
// ctf_back
// Walks the text template of one classified request and sends one character
// per cycle, taking the next request straight after the last character if one is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_back
   import ctf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  ctf_entry_type      head_entry,
   input  wire logic          q_empty,
   output logic               q_pop,
   output logic               rsp_strobe,
   output ctf_rsp_type        rsp_data
);

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_COLON = 7'h3A;
   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_A     = 7'h41;
   localparam logic [6:0] CH_P     = 7'h50;
   localparam logic [6:0] CH_M     = 7'h4D;

   typedef enum logic [3:0] {
      ST_WD0, ST_WD1, ST_WD2, ST_WSP,
      ST_HT, ST_HU, ST_C1, ST_MT, ST_MU,
      ST_C2, ST_ST, ST_SU,
      ST_ASP, ST_AP, ST_AM
   } step_type;

   // Three-letter weekday name, Sunday is zero
   function automatic logic [20:0] weekday_name(input logic [2:0] wd);
      logic [20:0] name;
      unique case (wd)
         3'd1:    name = {7'h4D, 7'h6F, 7'h6E};
         3'd2:    name = {7'h54, 7'h75, 7'h65};
         3'd3:    name = {7'h57, 7'h65, 7'h64};
         3'd4:    name = {7'h54, 7'h68, 7'h75};
         3'd5:    name = {7'h46, 7'h72, 7'h69};
         3'd6:    name = {7'h53, 7'h61, 7'h74};
         default: name = {7'h53, 7'h75, 7'h6E};
      endcase
      return name;
   endfunction

   step_type      step_ff;
   step_type      step_next;
   step_type      step_first;
   logic          active_ff;
   ctf_entry_type entry_ff;
   logic          rsp_strobe_ff;
   ctf_rsp_type   rsp_data_ff;
   logic [20:0]   name;
   logic [6:0]    char_in;
   logic          last_in;
   logic          load;

   // Pick the character and the following step
   always_comb begin
      name      = weekday_name(entry_ff.weekday);
      char_in   = CH_SPACE;
      last_in   = 1'b0;
      step_next = step_ff;
      unique case (step_ff)
         ST_WD0: begin
            char_in   = name[20:14];
            step_next = ST_WD1;
         end
         ST_WD1: begin
            char_in   = name[13:7];
            step_next = ST_WD2;
         end
         ST_WD2: begin
            char_in   = name[6:0];
            step_next = ST_WSP;
         end
         ST_WSP: begin
            char_in   = CH_SPACE;
            step_next = ST_HT;
         end
         ST_HT: begin
            char_in   = CH_ZERO + 7'(entry_ff.hour_tens);
            step_next = ST_HU;
         end
         ST_HU: begin
            char_in   = CH_ZERO + 7'(entry_ff.hour_units);
            step_next = ST_C1;
         end
         ST_C1: begin
            char_in   = CH_COLON;
            step_next = ST_MT;
         end
         ST_MT: begin
            char_in   = CH_ZERO + 7'(entry_ff.min_tens);
            step_next = ST_MU;
         end
         ST_MU: begin
            char_in = CH_ZERO + 7'(entry_ff.min_units);
            if (entry_ff.flags.show_seconds) begin
               step_next = ST_C2;
            end else if (!entry_ff.flags.use_24h) begin
               step_next = ST_ASP;
            end else begin
               last_in = 1'b1;
            end
         end
         ST_C2: begin
            char_in   = CH_COLON;
            step_next = ST_ST;
         end
         ST_ST: begin
            char_in   = CH_ZERO + 7'(entry_ff.sec_tens);
            step_next = ST_SU;
         end
         ST_SU: begin
            char_in = CH_ZERO + 7'(entry_ff.sec_units);
            if (!entry_ff.flags.use_24h) begin
               step_next = ST_ASP;
            end else begin
               last_in = 1'b1;
            end
         end
         ST_ASP: begin
            char_in   = CH_SPACE;
            step_next = ST_AP;
         end
         ST_AP: begin
            char_in   = entry_ff.pm ? CH_P : CH_A;
            step_next = ST_AM;
         end
         ST_AM: begin
            char_in = CH_M;
            last_in = 1'b1;
         end
         default: begin
            char_in = CH_SPACE;
         end
      endcase
      step_first = head_entry.flags.show_weekday ? ST_WD0 : ST_HT;
      load       = !active_ff || last_in;
      q_pop      = load && !q_empty;
   end

   // Hold step, current request and the registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         step_ff       <= ST_HT;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff         <= active_ff;
         rsp_data_ff.text_char <= char_in;
         rsp_data_ff.is_last   <= last_in;
         if (load) begin
            active_ff <= !q_empty;
            if (!q_empty) begin
               entry_ff <= head_entry;
               step_ff  <= step_first;
            end
         end else begin
            step_ff <= step_next;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/clock_text_formatter.sv =====
// ----------------------------------------------------------------------------
// clock_text_formatter
// Turns a calendar time into its clock text, one ASCII character per result.
// ----------------------------------------------------------------------------
// A taken request passes the weekday pipeline, the queue and the sequencer
// before its first character is registered. A text has 5 to 15 characters,
// sent one character per cycle; consecutive texts follow with no idle cycle.
// A request may be taken every cycle until the 4-entry queue plus the weekday
// pipeline hold 4 requests; busy is then high. Results cannot be stalled.
// Reset sets all three format options to 1 and empties pipeline and queue.
`default_nettype none

module clock_text_formatter
   import ctf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  ctf_req_type      req_data,
   output logic             rsp_strobe,
   output ctf_rsp_type      rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic        csr_data
);

   ctf_flags_type        flags_ff;
   logic [Q_CNT_W-1:0]   outstanding_ff;
   logic                 accept;
   logic                 push;
   ctf_entry_type        push_entry;
   ctf_entry_type        head_entry;
   logic                 q_empty;
   logic                 q_full;
   logic                 q_pop;

   assign csr_ready = 1'b1;
   assign busy      = outstanding_ff == Q_CNT_W'(Q_DEPTH);
   assign accept    = start && !busy;

   // Write the format options
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '{show_seconds: 1'b1, use_24h: 1'b1, show_weekday: 1'b1};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SHOW_SECONDS: flags_ff.show_seconds <= csr_data;
            CSR_USE_24H:      flags_ff.use_24h      <= csr_data;
            CSR_SHOW_WEEKDAY: flags_ff.show_weekday <= csr_data;
            default: ;
         endcase
      end
   end

   // Count requests taken but not yet handed to the sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (accept && !q_pop) begin
         outstanding_ff <= outstanding_ff + Q_CNT_W'(1);
      end else if (q_pop && !accept) begin
         outstanding_ff <= outstanding_ff - Q_CNT_W'(1);
      end
   end

   ctf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .flags      (flags_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   ctf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   ctf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // The credit count keeps the queue from overflowing
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("queue pushed while full");

   // A pop returns a credit that was handed out
   a_pop_has_credit: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> outstanding_ff != Q_CNT_W'(0))
      else $error("pop without outstanding request");

   // A taken request is counted on the next cycle
   a_accept_counted: assert property (@(posedge clock) disable iff (reset)
      accept |=> outstanding_ff != Q_CNT_W'(0))
      else $error("taken request not counted");

   // A run of characters only ends on a last character
   a_text_ends_last: assert property (@(posedge clock) disable iff (reset)
      ($fell(rsp_strobe) && !$past(reset)) |-> $past(rsp_data.is_last))
      else $error("text ended without last character");

endmodule

`default_nettype wire

// ===== bench/clock_text_formatter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_text_formatter_tb
// Sends calendar times to the clock text formatter under several format
// settings and compares every character that comes back with the text
// predicted inside the bench. The sender idles at varying rates.
// ----------------------------------------------------------------------------

module clock_text_formatter_tb;
   import ctf_pkg::*;

   localparam int DRAIN_CYCLES   = 1000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int BLOCK_ITEMS    = 30;
   localparam int BLOCKS_PER_RUN = 3;
   localparam int REPORT_LIMIT   = 10;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   ctf_req_type req_data;
   logic        rsp_strobe;
   ctf_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic        csr_data;

   // Expected characters, oldest first, and the format they are predicted under
   ctf_rsp_type   pending_chars[$];
   ctf_flags_type format_now;

   string weekday_names [7] = '{"Sun", "Mon", "Tue", "Wed", "Thu", "Fri", "Sat"};

   int failures        = 0;
   int sender_idle_pct = 0;
   bit req_offered     = 1'b0;

   clock_text_formatter uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Count a failure; print only the first few
   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   // Weekday by Zeller's congruence, 0 is Sunday
   function automatic int weekday_of(input logic [13:0] yr, input logic [3:0] mo,
                                     input logic [4:0] dy);
      int y;
      int m;
      int k;
      int c;
      int h;
      y = int'(yr) % 400 + 400;
      m = int'(mo);
      if (m < 3) begin
         m += 12;
         y -= 1;
      end
      k = y % 100;
      c = y / 100;
      h = (int'(dy) + (13 * (m + 1)) / 5 + k + k / 4 + c / 4 + 5 * c) % 7;
      return (h + 6) % 7;
   endfunction

   function automatic void put_char(ref ctf_rsp_type text[$], input byte ch);
      ctf_rsp_type r;
      r.text_char = ch[6:0];
      r.is_last   = 1'b0;
      text.push_back(r);
   endfunction

   // Tens digit wraps at ten, so any value shows as two digits
   function automatic void put_digits(ref ctf_rsp_type text[$], input int v);
      put_char(text, byte'("0") + byte'((v / 10) % 10));
      put_char(text, byte'("0") + byte'(v % 10));
   endfunction

   // Predict the clock text of one time and queue it
   function automatic void format_clock_text(input ctf_req_type t);
      ctf_rsp_type text[$];
      int          shown_hour;
      int          wd;
      shown_hour = int'(t.hour);
      if (format_now.show_weekday) begin
         wd = weekday_of(t.year, t.month, t.day);
         for (int i = 0; i < 3; i++) begin
            put_char(text, weekday_names[wd][i]);
         end
         put_char(text, " ");
      end
      if (!format_now.use_24h) begin
         shown_hour = shown_hour % 12;
         if (shown_hour == 0) begin
            shown_hour = 12;
         end
      end
      put_digits(text, shown_hour);
      put_char(text, ":");
      put_digits(text, int'(t.minute));
      if (format_now.show_seconds) begin
         put_char(text, ":");
         put_digits(text, int'(t.second));
      end
      if (!format_now.use_24h) begin
         put_char(text, " ");
         put_char(text, (t.hour < 5'd12) ? byte'("A") : byte'("P"));
         put_char(text, "M");
      end
      text[text.size() - 1].is_last = 1'b1;
      foreach (text[i]) begin
         pending_chars.push_back(text[i]);
      end
   endfunction

   function automatic ctf_req_type make_time(input int yr, input int mo, input int dy,
                                             input int hr, input int mi, input int se);
      ctf_req_type t;
      t.year   = 14'(yr);
      t.month  = 4'(mo);
      t.day    = 5'(dy);
      t.hour   = 5'(hr);
      t.minute = 6'(mi);
      t.second = 6'(se);
      return t;
   endfunction

   // Mostly valid dates and times, a quarter over the full field widths
   function automatic ctf_req_type random_time();
      ctf_req_type t;
      if ($urandom_range(0, 3) == 0) begin
         t.year   = 14'($urandom);
         t.month  = 4'($urandom);
         t.day    = 5'($urandom);
         t.hour   = 5'($urandom);
         t.minute = 6'($urandom);
         t.second = 6'($urandom);
      end else begin
         t = make_time($urandom_range(1, 9999), $urandom_range(1, 12),
                       $urandom_range(1, 31), $urandom_range(0, 23),
                       $urandom_range(0, 59), $urandom_range(0, 59));
      end
      return t;
   endfunction

   // Offer one request after a random gap; hold start high until it is taken
   task automatic send_time(input ctf_req_type t);
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         if (req_offered) begin
            start <= 1'b0;
            req_offered = 1'b0;
         end
         do @(posedge clock); while ($urandom_range(0, 99) < sender_idle_pct);
      end
      req_data <= t;
      start    <= 1'b1;
      req_offered = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      format_clock_text(t);
   endtask

   // Drop start and wait until every expected character has come back or the drain limit runs out
   task automatic drain_chars();
      int waited;
      waited = 0;
      if (req_offered) begin
         start <= 1'b0;
         req_offered = 1'b0;
      end
      while (pending_chars.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Write all three format registers once the block is idle
   task automatic set_format(input ctf_flags_type f);
      logic [1:0] reg_index [3];
      logic       reg_value [3];
      reg_index = '{CSR_SHOW_SECONDS, CSR_USE_24H, CSR_SHOW_WEEKDAY};
      reg_value = '{f.show_seconds, f.use_24h, f.show_weekday};
      drain_chars();
      csr_valid <= 1'b1;
      for (int i = 0; i < 3; i++) begin
         csr_index <= reg_index[i];
         csr_data  <= reg_value[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      format_now = f;
      csr_valid <= 1'b0;
   endtask

   // Format after reset: weekday, 24-hour form, seconds
   task automatic test_default_format();
      send_time(make_time(1, 1, 1, 0, 0, 0));
      send_time(make_time(9999, 12, 31, 23, 59, 59));
      send_time(make_time(16383, 15, 31, 31, 63, 63));
      send_time(make_time(2000, 2, 29, 12, 30, 45));
   endtask

   // Month zero, year zero before March, months past December, day zero
   task automatic test_calendar_edges();
      send_time(make_time(2024, 0, 15, 8, 5, 9));
      send_time(make_time(0, 1, 1, 1, 2, 3));
      send_time(make_time(0, 2, 28, 4, 5, 6));
      send_time(make_time(2023, 13, 5, 10, 20, 30));
      send_time(make_time(2023, 14, 9, 11, 21, 31));
      send_time(make_time(2023, 15, 17, 12, 22, 32));
      send_time(make_time(2023, 3, 0, 13, 23, 33));
   endtask

   // 12-hour form across midnight, noon and out-of-range hours
   task automatic test_twelve_hour();
      set_format('{show_seconds: 1'b1, use_24h: 1'b0, show_weekday: 1'b1});
      send_time(make_time(2021, 6, 1, 0, 0, 0));
      send_time(make_time(2021, 6, 2, 11, 59, 59));
      send_time(make_time(2021, 6, 3, 12, 0, 1));
      send_time(make_time(2021, 6, 4, 13, 14, 15));
      send_time(make_time(2021, 6, 5, 23, 45, 50));
      send_time(make_time(2021, 6, 6, 24, 1, 2));
      send_time(make_time(2021, 6, 7, 31, 63, 63));
   endtask

   // Shortest texts: no weekday, no seconds, both hour forms
   task automatic test_short_formats();
      set_format('{show_seconds: 1'b0, use_24h: 1'b0, show_weekday: 1'b0});
      send_time(make_time(1999, 12, 31, 0, 7, 8));
      send_time(make_time(1999, 12, 31, 18, 59, 0));
      set_format('{show_seconds: 1'b0, use_24h: 1'b1, show_weekday: 1'b0});
      send_time(make_time(4321, 7, 4, 9, 3, 0));
      send_time(make_time(4321, 7, 4, 30, 60, 0));
   endtask

   // Random times in blocks, a random format for each block
   task automatic test_random_times(input int idle_pct);
      ctf_flags_type f;
      sender_idle_pct = idle_pct;
      for (int b = 0; b < BLOCKS_PER_RUN; b++) begin
         f.show_seconds = 1'($urandom);
         f.use_24h      = 1'($urandom);
         f.show_weekday = 1'($urandom);
         set_format(f);
         repeat (BLOCK_ITEMS) send_time(random_time());
      end
   endtask

   // Compare each character with the oldest expectation
   always @(posedge clock) begin
      ctf_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_chars.size() == 0) begin
            note_failure($sformatf("character 0x%02h with no text expected",
                                   rsp_data.text_char));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.text_char !== want.text_char || rsp_data.is_last !== want.is_last) begin
               note_failure($sformatf("char expected 0x%02h last %0b, got 0x%02h last %0b",
                                      want.text_char, want.is_last,
                                      rsp_data.text_char, rsp_data.is_last));
            end
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SHOW_SECONDS;
      csr_data  <= 1'b0;
      format_now = '{show_seconds: 1'b1, use_24h: 1'b1, show_weekday: 1'b1};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 34;
      test_default_format();
      test_calendar_edges();
      test_twelve_hour();
      test_short_formats();
      test_random_times(34);
      test_random_times(59);
      test_random_times(0);

      drain_chars();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         note_failure($sformatf("%0d characters never arrived", pending_chars.size()));
      end
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
